// ----- hdl/grid_cell_cursor_lookup_macros.svh -----
// Assertion helpers shared by the lookup block.
`ifndef GRID_CELL_CURSOR_LOOKUP_MACROS_SVH
`define GRID_CELL_CURSOR_LOOKUP_MACROS_SVH

// Checked on every edge outside reset.
`define GCCL_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define GCCL_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

// ----- hdl/gccl_pkg.sv -----
package gccl_pkg;

    // grid geometry and field widths
    localparam int MAX_COLS   = 512;
    localparam int MAX_ROWS   = 512;
    localparam int COORD_BITS = 32;
    localparam int DEPTH_BITS = 16;

    localparam int CMD_W     = 2;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int WD_W      = DEPTH_BITS - 1;

    // both coordinate tables share one walker layout
    localparam int WALK_DEPTH = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int IDX_W      = (WALK_DEPTH > 1) ? $clog2(WALK_DEPTH) : 1;
    localparam int CNT_W      = $clog2(WALK_DEPTH + 1);
    localparam int Q2_W       = COORD_BITS + 2;

    localparam int GRID_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int GRID_AW    = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;

    // command queue between front and back, power-of-two depth
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int SHALLOW_LIMIT = 20;
    localparam logic signed [DEPTH_BITS-1:0] SHALLOW_POS = DEPTH_BITS'(SHALLOW_LIMIT);
    localparam logic signed [DEPTH_BITS-1:0] SHALLOW_NEG = -SHALLOW_POS;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_X_WR  = 2'd0,
        CMD_Y_WR  = 2'd1,
        CMD_Z_WR  = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    // one classified word in the queue
    typedef struct packed {
        cmd_t                          op;
        logic                          idx_ok;
        logic [COL_W-1:0]              col;
        logic [ROW_W-1:0]              row;
        logic signed [COORD_BITS-1:0]  val_a;
        logic signed [COORD_BITS-1:0]  val_b;
        logic signed [DEPTH_BITS-1:0]  depth;
    } entry_t;

    typedef struct packed {
        logic                          start;
        logic                          clr;
        logic                          wr_en;
        logic [IDX_W-1:0]              wr_addr;
        logic signed [COORD_BITS-1:0]  wr_data;
    } walk_ctl_t;

    typedef struct packed {
        logic             busy;
        logic [IDX_W-1:0] cur;
    } walk_stat_t;

    typedef enum logic [2:0] {
        W_IDLE,
        W_LRD,
        W_LCMP,
        W_RRD,
        W_RCMP
    } walk_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_WALK,
        B_GRID
    } back_state_t;

    // sample count in use: zero counts as one, large values clip to the table size
    function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] raw,
                                                   input int max_n);
        logic [31:0] r;
        r = 32'(raw);
        if (r == 32'd0) begin
            r = 32'd1;
        end else if (r > 32'(max_n)) begin
            r = 32'(max_n);
        end
        return CNT_W'(r);
    endfunction

endpackage

// ----- hdl/gccl_front.sv -----
module gccl_front (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [gccl_pkg::CMD_W-1:0]              s_cmd,
    input  logic [gccl_pkg::COL_W-1:0]              s_col,
    input  logic [gccl_pkg::ROW_W-1:0]              s_row,
    input  logic signed [gccl_pkg::COORD_BITS-1:0]  s_coord,
    input  logic signed [gccl_pkg::DEPTH_BITS-1:0]  s_depth_sample,
    input  logic signed [gccl_pkg::COORD_BITS-1:0]  s_query_x,
    input  logic signed [gccl_pkg::COORD_BITS-1:0]  s_query_y,
    output gccl_pkg::entry_t                        head,
    output logic                                    head_valid,
    input  logic                                    pop
);

    gccl_pkg::entry_t                   q_mem [gccl_pkg::QDEPTH];
    gccl_pkg::entry_t                   in_ent;
    logic [gccl_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [gccl_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [gccl_pkg::QCNT_W-1:0]        cnt_reg, cnt_next;
    logic                               push;

    // classify the incoming word and check its write index
    always_comb begin
        in_ent.op    = gccl_pkg::cmd_t'(s_cmd);
        in_ent.col   = s_col;
        in_ent.row   = s_row;
        in_ent.depth = s_depth_sample;
        in_ent.val_b = s_query_y;
        in_ent.val_a = (in_ent.op == gccl_pkg::CMD_QUERY) ? s_query_x : s_coord;
        case (in_ent.op)
            gccl_pkg::CMD_X_WR: begin
                in_ent.idx_ok = 32'(s_col) < 32'(gccl_pkg::MAX_COLS);
            end
            gccl_pkg::CMD_Y_WR: begin
                in_ent.idx_ok = 32'(s_row) < 32'(gccl_pkg::MAX_ROWS);
            end
            gccl_pkg::CMD_Z_WR: begin
                in_ent.idx_ok = (32'(s_col) < 32'(gccl_pkg::MAX_COLS)) &&
                                (32'(s_row) < 32'(gccl_pkg::MAX_ROWS));
            end
            default: begin
                in_ent.idx_ok = 1'b1;
            end
        endcase
    end

    assign s_ready    = (cnt_reg != gccl_pkg::QCNT_W'(gccl_pkg::QDEPTH));
    assign push       = s_valid && s_ready;
    assign head_valid = (cnt_reg != '0);
    assign head       = q_mem[rd_ptr_reg];

    // queue pointers
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_ent;
        end
    end

endmodule

// ----- hdl/gccl_walk.sv -----
module gccl_walk (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  gccl_pkg::walk_ctl_t                 ctl,
    input  logic signed [gccl_pkg::Q2_W-1:0]    q2,
    input  logic [gccl_pkg::CNT_W-1:0]          n,
    output gccl_pkg::walk_stat_t                stat
);

    logic signed [gccl_pkg::COORD_BITS-1:0] tab_mem [gccl_pkg::WALK_DEPTH];

    gccl_pkg::walk_state_t                  state_reg, state_next;
    logic [gccl_pkg::IDX_W-1:0]             cur_reg, cur_next;
    logic signed [gccl_pkg::Q2_W-1:0]       q2_reg;
    logic signed [gccl_pkg::COORD_BITS-1:0] rd_a_reg, rd_b_reg;
    logic signed [gccl_pkg::Q2_W-1:0]       sum;
    logic [gccl_pkg::IDX_W-1:0]             addr_a, addr_b;
    logic                                   rd_en;
    logic                                   at_first, at_last;
    logic                                   go_left, go_right;

    // midpoint test: 2*q against the sum of two neighboring samples
    assign sum = $signed({{2{rd_a_reg[gccl_pkg::COORD_BITS-1]}}, rd_a_reg}) +
                 $signed({{2{rd_b_reg[gccl_pkg::COORD_BITS-1]}}, rd_b_reg});
    assign go_left  = (q2_reg < sum);
    assign go_right = (q2_reg > sum);
    assign at_first = (cur_reg == '0);
    assign at_last  = ((gccl_pkg::CNT_W'(cur_reg) + 1'b1) >= n);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gccl_pkg::W_IDLE: begin
                if (ctl.start) state_next = gccl_pkg::W_LRD;
            end
            gccl_pkg::W_LRD: begin
                state_next = at_first ? gccl_pkg::W_RRD : gccl_pkg::W_LCMP;
            end
            gccl_pkg::W_LCMP: begin
                state_next = go_left ? gccl_pkg::W_LRD : gccl_pkg::W_RRD;
            end
            gccl_pkg::W_RRD: begin
                state_next = at_last ? gccl_pkg::W_IDLE : gccl_pkg::W_RCMP;
            end
            gccl_pkg::W_RCMP: begin
                state_next = go_right ? gccl_pkg::W_RRD : gccl_pkg::W_IDLE;
            end
            default: begin
                state_next = gccl_pkg::W_IDLE;
            end
        endcase
    end

    // table read addresses
    always_comb begin
        rd_en  = 1'b0;
        addr_a = cur_reg;
        addr_b = cur_reg;
        case (state_reg)
            gccl_pkg::W_LRD: begin
                rd_en  = !at_first;
                addr_a = cur_reg - 1'b1;
            end
            gccl_pkg::W_RRD: begin
                rd_en  = !at_last;
                addr_b = cur_reg + 1'b1;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign stat.busy = (state_reg != gccl_pkg::W_IDLE);
    assign stat.cur  = cur_reg;

    // cursor: cleared by loads, clamped at start, stepped by the walk
    always_comb begin
        cur_next = cur_reg;
        if (ctl.clr) begin
            cur_next = '0;
        end else if ((state_reg == gccl_pkg::W_IDLE) && ctl.start) begin
            if (gccl_pkg::CNT_W'(cur_reg) >= n) begin
                cur_next = gccl_pkg::IDX_W'(n - 1'b1);
            end
        end else if ((state_reg == gccl_pkg::W_LCMP) && go_left) begin
            cur_next = cur_reg - 1'b1;
        end else if ((state_reg == gccl_pkg::W_RCMP) && go_right) begin
            cur_next = cur_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gccl_pkg::W_IDLE;
            cur_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
        end
    end

    // query point held for the whole walk
    always_ff @(posedge aclk) begin
        if ((state_reg == gccl_pkg::W_IDLE) && ctl.start) begin
            q2_reg <= q2;
        end
    end

    // sample table: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            tab_mem[ctl.wr_addr] <= ctl.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= tab_mem[addr_a];
            rd_b_reg <= tab_mem[addr_b];
        end
    end

endmodule

// ----- hdl/gccl_back.sv -----
module gccl_back (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic [gccl_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [gccl_pkg::CFG_W-1:0]              cfg_wdata,
    input  gccl_pkg::entry_t                        head,
    input  logic                                    head_valid,
    output logic                                    pop,
    output gccl_pkg::walk_ctl_t                     x_ctl,
    output gccl_pkg::walk_ctl_t                     y_ctl,
    output logic signed [gccl_pkg::Q2_W-1:0]        x_q2,
    output logic signed [gccl_pkg::Q2_W-1:0]        y_q2,
    output logic [gccl_pkg::CNT_W-1:0]              x_n,
    output logic [gccl_pkg::CNT_W-1:0]              y_n,
    input  gccl_pkg::walk_stat_t                    x_stat,
    input  gccl_pkg::walk_stat_t                    y_stat,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [gccl_pkg::DEPTH_BITS-1:0]  m_bathymetry,
    output logic [gccl_pkg::WD_W-1:0]               m_water_depth,
    output logic [gccl_pkg::COL_W-1:0]              m_cell_col,
    output logic [gccl_pkg::ROW_W-1:0]              m_cell_row
);

    logic signed [gccl_pkg::DEPTH_BITS-1:0] grid_mem [gccl_pkg::GRID_DEPTH];

    gccl_pkg::back_state_t                  state_reg, state_next;
    logic [gccl_pkg::CFG_W-1:0]             cols_used_reg, rows_used_reg;
    logic signed [gccl_pkg::COORD_BITS-1:0] x0_reg, y0_reg;
    logic signed [gccl_pkg::DEPTH_BITS-1:0] grid_rd_reg;
    logic                                   m_valid_reg;
    logic signed [gccl_pkg::DEPTH_BITS-1:0] bath_reg;
    logic [gccl_pkg::WD_W-1:0]              wd_reg;
    logic [gccl_pkg::COL_W-1:0]             col_reg;
    logic [gccl_pkg::ROW_W-1:0]             row_reg;

    logic signed [gccl_pkg::COORD_BITS:0]   qx, qy;
    logic                                   is_query, walks_idle;
    logic                                   grid_wr_en, grid_rd_en, load;
    logic [gccl_pkg::GRID_AW-1:0]           grid_wr_addr, grid_rd_addr;
    logic signed [gccl_pkg::DEPTH_BITS-1:0] bath_shaped;
    logic signed [gccl_pkg::DEPTH_BITS:0]   bath_neg;
    logic [gccl_pkg::WD_W-1:0]              wd;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_used_reg <= gccl_pkg::CFG_W'(gccl_pkg::MAX_COLS);
            rows_used_reg <= gccl_pkg::CFG_W'(gccl_pkg::MAX_ROWS);
        end else if (cfg_wr_en) begin
            if (cfg_index == gccl_pkg::CFG_COLS_USED) cols_used_reg <= cfg_wdata;
            if (cfg_index == gccl_pkg::CFG_ROWS_USED) rows_used_reg <= cfg_wdata;
        end
    end

    assign x_n = gccl_pkg::eff_count(cols_used_reg, gccl_pkg::MAX_COLS);
    assign y_n = gccl_pkg::eff_count(rows_used_reg, gccl_pkg::MAX_ROWS);

    // query point offset by the first samples, doubled for the midpoint test
    assign qx   = $signed({head.val_a[gccl_pkg::COORD_BITS-1], head.val_a}) +
                  $signed({x0_reg[gccl_pkg::COORD_BITS-1], x0_reg});
    assign qy   = $signed({head.val_b[gccl_pkg::COORD_BITS-1], head.val_b}) +
                  $signed({y0_reg[gccl_pkg::COORD_BITS-1], y0_reg});
    assign x_q2 = {qx, 1'b0};
    assign y_q2 = {qy, 1'b0};

    assign is_query   = (head.op == gccl_pkg::CMD_QUERY);
    assign walks_idle = !x_stat.busy && !y_stat.busy;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gccl_pkg::B_IDLE: begin
                if (head_valid && is_query) state_next = gccl_pkg::B_WALK;
            end
            gccl_pkg::B_WALK: begin
                if (walks_idle) state_next = gccl_pkg::B_GRID;
            end
            gccl_pkg::B_GRID: begin
                if (!m_valid_reg || m_ready) state_next = gccl_pkg::B_IDLE;
            end
            default: begin
                state_next = gccl_pkg::B_IDLE;
            end
        endcase
    end

    // dispatch: loads are written as they are popped, queries start both walkers
    always_comb begin
        pop          = (state_reg == gccl_pkg::B_IDLE) && head_valid;
        x_ctl.start  = pop && is_query;
        y_ctl.start  = pop && is_query;
        x_ctl.clr    = pop && !is_query;
        y_ctl.clr    = pop && !is_query;
        x_ctl.wr_en  = pop && (head.op == gccl_pkg::CMD_X_WR) && head.idx_ok;
        y_ctl.wr_en  = pop && (head.op == gccl_pkg::CMD_Y_WR) && head.idx_ok;
        x_ctl.wr_addr = gccl_pkg::IDX_W'(head.col);
        y_ctl.wr_addr = gccl_pkg::IDX_W'(head.row);
        x_ctl.wr_data = head.val_a;
        y_ctl.wr_data = head.val_a;
        grid_wr_en   = pop && (head.op == gccl_pkg::CMD_Z_WR) && head.idx_ok;
        grid_rd_en   = (state_reg == gccl_pkg::B_WALK) && walks_idle;
        load         = (state_reg == gccl_pkg::B_GRID) && (!m_valid_reg || m_ready);
    end

    assign grid_wr_addr = gccl_pkg::GRID_AW'(32'(head.row) * gccl_pkg::MAX_COLS +
                                             32'(head.col));
    assign grid_rd_addr = gccl_pkg::GRID_AW'(32'(y_stat.cur) * gccl_pkg::MAX_COLS +
                                             32'(x_stat.cur));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gccl_pkg::B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // copies of the first samples for the query offset
    always_ff @(posedge aclk) begin
        if (x_ctl.wr_en && (head.col == '0)) x0_reg <= head.val_a;
        if (y_ctl.wr_en && (head.row == '0)) y0_reg <= head.val_a;
    end

    // bathymetry grid
    always_ff @(posedge aclk) begin
        if (grid_wr_en) begin
            grid_mem[grid_wr_addr] <= head.depth;
        end
    end

    always_ff @(posedge aclk) begin
        if (grid_rd_en) begin
            grid_rd_reg <= grid_mem[grid_rd_addr];
        end
    end

    // push shallow values out to +-20, water depth saturates
    always_comb begin
        bath_shaped = grid_rd_reg;
        if (!grid_rd_reg[gccl_pkg::DEPTH_BITS-1] && (grid_rd_reg < gccl_pkg::SHALLOW_POS)) begin
            bath_shaped = gccl_pkg::SHALLOW_POS;
        end else if (grid_rd_reg[gccl_pkg::DEPTH_BITS-1] &&
                     (grid_rd_reg > gccl_pkg::SHALLOW_NEG)) begin
            bath_shaped = gccl_pkg::SHALLOW_NEG;
        end
        bath_neg = -$signed({bath_shaped[gccl_pkg::DEPTH_BITS-1], bath_shaped});
        if (!bath_shaped[gccl_pkg::DEPTH_BITS-1]) begin
            wd = '0;
        end else if (bath_neg[gccl_pkg::DEPTH_BITS-1]) begin
            wd = '1;
        end else begin
            wd = bath_neg[gccl_pkg::WD_W-1:0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bath_reg <= bath_shaped;
            wd_reg   <= wd;
            col_reg  <= gccl_pkg::COL_W'(x_stat.cur);
            row_reg  <= gccl_pkg::ROW_W'(y_stat.cur);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_bathymetry  = bath_reg;
    assign m_water_depth = wd_reg;
    assign m_cell_col    = col_reg;
    assign m_cell_row    = row_reg;

endmodule

// ----- hdl/grid_cell_cursor_lookup.sv -----
// Nearest-sample lookup on a rectilinear grid. Words with cmd 0, 1 and 2 load the x table,
// the y table and the bathymetry grid, and each one returns the cell cursor to (0,0); a
// query word (cmd 3) walks the kept cursor to the cell that holds the point and returns
// one result word with the shaped bathymetry, the water depth and the cell indices. A
// four-word queue sits behind the input, so loads and queries keep arriving while the
// back end works or a result waits to be taken. In the back end a load is done as it is
// popped. A query walks the cursor one cell per step; the x and y walkers run side by
// side, so the axis with more steps sets the query time. Each step is a registered
// two-port read of a sample table followed by the midpoint compare. cols_used and
// rows_used must be written by the user only while the block is idle; the block itself
// does not enforce this. Zero counts as one sample.
`include "grid_cell_cursor_lookup_macros.svh"

module grid_cell_cursor_lookup (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic [gccl_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [gccl_pkg::CFG_W-1:0]              cfg_wdata,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [gccl_pkg::CMD_W-1:0]              s_cmd,
    input  logic [gccl_pkg::COL_W-1:0]              s_col,
    input  logic [gccl_pkg::ROW_W-1:0]              s_row,
    input  logic signed [gccl_pkg::COORD_BITS-1:0]  s_coord,
    input  logic signed [gccl_pkg::DEPTH_BITS-1:0]  s_depth_sample,
    input  logic signed [gccl_pkg::COORD_BITS-1:0]  s_query_x,
    input  logic signed [gccl_pkg::COORD_BITS-1:0]  s_query_y,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [gccl_pkg::DEPTH_BITS-1:0]  m_bathymetry,
    output logic [gccl_pkg::WD_W-1:0]               m_water_depth,
    output logic [gccl_pkg::COL_W-1:0]              m_cell_col,
    output logic [gccl_pkg::ROW_W-1:0]              m_cell_row
);

    gccl_pkg::entry_t                   head;
    logic                               head_valid;
    logic                               pop;
    gccl_pkg::walk_ctl_t                x_ctl, y_ctl;
    gccl_pkg::walk_stat_t               x_stat, y_stat;
    logic signed [gccl_pkg::Q2_W-1:0]   x_q2, y_q2;
    logic [gccl_pkg::CNT_W-1:0]         x_n, y_n;

    // accept and classify, queue
    gccl_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_col          (s_col),
        .s_row          (s_row),
        .s_coord        (s_coord),
        .s_depth_sample (s_depth_sample),
        .s_query_x      (s_query_x),
        .s_query_y      (s_query_y),
        .head           (head),
        .head_valid     (head_valid),
        .pop            (pop)
    );

    // dispatch, grid lookup and result register
    gccl_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .x_ctl         (x_ctl),
        .y_ctl         (y_ctl),
        .x_q2          (x_q2),
        .y_q2          (y_q2),
        .x_n           (x_n),
        .y_n           (y_n),
        .x_stat        (x_stat),
        .y_stat        (y_stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bathymetry  (m_bathymetry),
        .m_water_depth (m_water_depth),
        .m_cell_col    (m_cell_col),
        .m_cell_row    (m_cell_row)
    );

    // column walker with the x table
    gccl_walk u_walk_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (x_ctl),
        .q2      (x_q2),
        .n       (x_n),
        .stat    (x_stat)
    );

    // row walker with the y table
    gccl_walk u_walk_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (y_ctl),
        .q2      (y_q2),
        .n       (y_n),
        .stat    (y_stat)
    );

    `GCCL_ASSERT(a_load_clears_cursor, x_ctl.clr |=> (x_stat.cur == '0) && (y_stat.cur == '0), "load did not clear cursor")
    `GCCL_ASSERT(a_pop_walks_idle, pop |-> !x_stat.busy && !y_stat.busy, "word dispatched during a walk")
    `GCCL_ASSERT(a_result_after_walk, $rose(m_valid) |-> !x_stat.busy && !y_stat.busy, "result raised while walking")
    `GCCL_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_valid && !x_stat.busy && !y_stat.busy, "not quiet after reset")

endmodule

// ----- tb/grid_cell_cursor_lookup_test.sv -----
`timescale 1ns / 100ps

module grid_cell_cursor_lookup_test;
    import gccl_pkg::*;

    localparam int RANDOM_WORDS = 1500;
    localparam int LOAD_TAIL    = 16;
    localparam int STALL_LIMIT  = 20000;
    localparam int REG_TOP      = (1 << CFG_W) - 1;

    localparam logic signed [DEPTH_BITS-1:0] DEEPEST = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic [WD_W-1:0]              WD_MAX  = '1;

    // one input word as the block sees it
    typedef struct packed {
        cmd_t                         cmd;
        logic [COL_W-1:0]             col;
        logic [ROW_W-1:0]             row;
        logic signed [COORD_BITS-1:0] coord;
        logic signed [DEPTH_BITS-1:0] depth;
        logic signed [COORD_BITS-1:0] query_x;
        logic signed [COORD_BITS-1:0] query_y;
    } word_t;

    // one result word
    typedef struct packed {
        logic signed [DEPTH_BITS-1:0] bathymetry;
        logic [WD_W-1:0]              water_depth;
        logic [COL_W-1:0]             col;
        logic [ROW_W-1:0]             row;
    } cell_t;

    // directed step: a register write or a word, with an optional known answer
    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        int                   reg_val;
        word_t                w;
        bit                   known;
        cell_t                want;
    } plan_row_t;

    typedef longint axis_t [WALK_DEPTH];

    logic aclk      = 1'b0;
    logic aresetn   = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CMD_W-1:0]             s_cmd          = '0;
    logic [COL_W-1:0]             s_col          = '0;
    logic [ROW_W-1:0]             s_row          = '0;
    logic signed [COORD_BITS-1:0] s_coord        = '0;
    logic signed [DEPTH_BITS-1:0] s_depth_sample = '0;
    logic signed [COORD_BITS-1:0] s_query_x      = '0;
    logic signed [COORD_BITS-1:0] s_query_y      = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [DEPTH_BITS-1:0] m_bathymetry;
    logic [WD_W-1:0]              m_water_depth;
    logic [COL_W-1:0]             m_cell_col;
    logic [ROW_W-1:0]             m_cell_row;

    // mirror of the block's state
    axis_t xs_mirror;
    axis_t ys_mirror;
    logic signed [DEPTH_BITS-1:0] bathy_mirror [int];
    int cur_col = 0;
    int cur_row = 0;
    logic [CFG_W-1:0] cols_reg = CFG_W'(MAX_COLS);
    logic [CFG_W-1:0] rows_reg = CFG_W'(MAX_ROWS);

    cell_t     pending_cells [$];
    plan_row_t plan [$];
    int    fail_count  = 0;
    int    sink_wait   = 0;
    int    idle_cycles = 0;
    bit    calm        = 1'b0;

    always #6 aclk = ~aclk;

    grid_cell_cursor_lookup u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_col          (s_col),
        .s_row          (s_row),
        .s_coord        (s_coord),
        .s_depth_sample (s_depth_sample),
        .s_query_x      (s_query_x),
        .s_query_y      (s_query_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bathymetry   (m_bathymetry),
        .m_water_depth  (m_water_depth),
        .m_cell_col     (m_cell_col),
        .m_cell_row     (m_cell_row)
    );

    // ---------------------------------------------------------------- queues

    // expected result words, oldest first
    function automatic void queue_cell(input cell_t c);
        pending_cells.insert(pending_cells.size(), c);
    endfunction

    // directed steps in the order they run
    function automatic void add_row(input plan_row_t r);
        plan.insert(plan.size(), r);
    endfunction

    // ---------------------------------------------------------------- prediction

    // samples in use: zero means one, oversize clips to the table
    function automatic int usable(input logic [CFG_W-1:0] raw, input int top);
        if (raw == '0) begin
            return 1;
        end
        return (int'(raw) > top) ? top : int'(raw);
    endfunction

    // move the kept cursor until 2q sits between the neighboring midpoints
    function automatic int step_cursor(input axis_t tab, input int n, input int cur,
                                       input longint q);
        longint q2;
        int     c;
        q2 = q * 2;
        c  = (cur >= n) ? n - 1 : cur;
        while (c > 0 && q2 < tab[c-1] + tab[c]) c--;
        while (c + 1 < n && q2 > tab[c] + tab[c+1]) c++;
        return c;
    endfunction

    // apply one accepted word; hit is set when it yields a result word
    function automatic void advance_model(input word_t w, output bit hit, output cell_t res);
        int     b;
        int     wd;
        longint qx;
        longint qy;
        hit = 1'b0;
        res = '0;
        if (w.cmd != CMD_QUERY) begin
            if (w.cmd == CMD_X_WR) begin
                xs_mirror[w.col] = longint'(w.coord);
            end else if (w.cmd == CMD_Y_WR) begin
                ys_mirror[w.row] = longint'(w.coord);
            end else begin
                bathy_mirror[int'({w.row, w.col})] = w.depth;
            end
            cur_col = 0;
            cur_row = 0;
            return;
        end
        qx = longint'(w.query_x) + xs_mirror[0];
        qy = longint'(w.query_y) + ys_mirror[0];
        cur_col = step_cursor(xs_mirror, usable(cols_reg, MAX_COLS), cur_col, qx);
        cur_row = step_cursor(ys_mirror, usable(rows_reg, MAX_ROWS), cur_row, qy);
        b = bathy_mirror.exists(cur_row * MAX_COLS + cur_col) ?
            int'(bathy_mirror[cur_row * MAX_COLS + cur_col]) : 0;
        // shallow cells pushed out to +-20
        if (b >= 0 && b < SHALLOW_LIMIT) begin
            b = SHALLOW_LIMIT;
        end else if (b < 0 && b > -SHALLOW_LIMIT) begin
            b = -SHALLOW_LIMIT;
        end
        wd = (b < 0) ? -b : 0;
        if (wd > int'(WD_MAX)) begin
            wd = int'(WD_MAX);
        end
        hit             = 1'b1;
        res.bathymetry  = DEPTH_BITS'(b);
        res.water_depth = WD_W'(wd);
        res.col         = COL_W'(cur_col);
        res.row         = ROW_W'(cur_row);
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic word_t blank_word();
        word_t w;
        w.cmd     = cmd_t'($urandom_range(0, 3));
        w.col     = COL_W'($urandom);
        w.row     = ROW_W'($urandom);
        w.coord   = COORD_BITS'($urandom);
        w.depth   = DEPTH_BITS'($urandom);
        w.query_x = COORD_BITS'($urandom);
        w.query_y = COORD_BITS'($urandom);
        return w;
    endfunction

    function automatic logic signed [DEPTH_BITS-1:0] pick_depth();
        case ($urandom_range(0, 7))
            0:       return DEEPEST;
            1:       return {1'b0, {(DEPTH_BITS-1){1'b1}}};
            2:       return DEPTH_BITS'(int'(DEEPEST) + 1);
            3, 4:    return DEPTH_BITS'(int'($urandom_range(0, 50)) - 25);
            default: return DEPTH_BITS'($urandom);
        endcase
    endfunction

    // query offset near a sample, on a midpoint, or anywhere at all
    function automatic logic signed [COORD_BITS-1:0] aim(input axis_t tab, input int n);
        int     k;
        longint t;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            0:       t = longint'($signed($urandom));
            1, 2:    t = (k + 1 < n) ? ((tab[k] + tab[k+1]) >>> 1) - tab[0] : tab[k] - tab[0];
            default: t = tab[k] - tab[0] + longint'($urandom_range(0, 16)) - 8;
        endcase
        return COORD_BITS'(t);
    endfunction

    function automatic int reg_code(input int n, input int top);
        if (n == 1) begin
            return $urandom_range(0, 1);
        end
        if (n == top) begin
            return $urandom_range(top, REG_TOP);
        end
        return n;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
        plan_row_t r;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        r.w       = blank_word();
        r.known   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    // value goes to coord for table loads and to depth for grid loads
    function automatic plan_row_t load_row(input cmd_t op, input int c, input int rw,
                                           input logic signed [COORD_BITS-1:0] v);
        plan_row_t r;
        r          = reg_row('0, 0);
        r.is_reg   = 1'b0;
        r.w.cmd    = op;
        r.w.col    = COL_W'(c);
        r.w.row    = ROW_W'(rw);
        r.w.coord  = v;
        r.w.depth  = DEPTH_BITS'(v);
        return r;
    endfunction

    function automatic plan_row_t ask_row(input logic signed [COORD_BITS-1:0] qx,
                                          input logic signed [COORD_BITS-1:0] qy,
                                          input bit known, input cell_t want);
        plan_row_t r;
        r           = reg_row('0, 0);
        r.is_reg    = 1'b0;
        r.w.cmd     = CMD_QUERY;
        r.w.query_x = qx;
        r.w.query_y = qy;
        r.known     = known;
        r.want      = want;
        return r;
    endfunction

    // ---------------------------------------------------------------- driving

    task automatic push_word(input word_t w, input bit known, input cell_t want);
        int    gap;
        bit    hit;
        cell_t got;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= w.cmd;
        s_col          <= w.col;
        s_row          <= w.row;
        s_coord        <= w.coord;
        s_depth_sample <= w.depth;
        s_query_x      <= w.query_x;
        s_query_y      <= w.query_y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_model(w, hit, got);
        if (hit) begin
            queue_cell(known ? want : got);
        end
    endtask

    // hold off until every result is back and trailing loads have drained
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (LOAD_TAIL) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(val);
        if (idx == CFG_COLS_USED) begin
            cols_reg = CFG_W'(val);
        end else begin
            rows_reg = CFG_W'(val);
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // one table of samples: increasing, flat, or scrambled
    task automatic fill_axis(input cmd_t op, input int n);
        word_t  w;
        longint v;
        int     style;
        int     stride_max;
        style      = $urandom_range(0, 5);
        stride_max = ($urandom_range(0, 1) != 0) ? 4 : (1 << 20);
        v          = longint'($urandom_range(0, 1 << 30)) - (1 << 29);
        for (int i = 0; i < n; i++) begin
            w     = blank_word();
            w.cmd = op;
            if (op == CMD_X_WR) begin
                w.col = COL_W'(i);
            end else begin
                w.row = ROW_W'(i);
            end
            if (style == 0) begin
                w.coord = COORD_BITS'($urandom);
            end else begin
                w.coord = COORD_BITS'(v);
                if (style != 1) begin
                    v += $urandom_range(1, stride_max);
                end
            end
            push_word(w, 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------- result check

    always @(posedge aclk) begin
        cell_t got;
        cell_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_bathymetry, m_water_depth, m_cell_col, m_cell_row};
            if (pending_cells.size() == 0) begin
                $display("%0t ns: unexpected result word, bath %0d depth %0d col %0d row %0d",
                         $time, got.bathymetry, got.water_depth, got.col, got.row);
                fail_count++;
            end else begin
                want = pending_cells.pop_front();
                if (got !== want) begin
                    $display({"%0t ns: mismatch, expected bath %0d depth %0d col %0d row %0d,",
                              " got bath %0d depth %0d col %0d row %0d"},
                             $time, want.bathymetry, want.water_depth, want.col, want.row,
                             got.bathymetry, got.water_depth, got.col, got.row);
                    fail_count++;
                end
            end
            sink_wait = calm ? 0 : $urandom_range(0, 15);
        end else if (sink_wait != 0) begin
            sink_wait--;
        end
        m_ready <= (sink_wait == 0);
    end

    // watchdog: cycles in a row with no word moving on any port
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        word_t     w;
        int        loose;
        int        phase;
        int        nc;
        int        nr;
        int        nq;
        int        fill_nc;
        int        fill_nr;
        bit        bulky;
        bit        shrink;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // single cell: coordinate extremes and depth shaping
        add_row(reg_row(CFG_COLS_USED, 0));
        add_row(reg_row(CFG_ROWS_USED, 0));
        add_row(load_row(CMD_X_WR, 0, 0, 32'sh8000_0000));
        add_row(load_row(CMD_Y_WR, 0, 0, 32'sh7fff_ffff));
        add_row(load_row(CMD_Z_WR, 0, 0, DEEPEST));
        add_row(ask_row(0, 0, 1'b1, cell_t'{DEEPEST, WD_MAX, 9'd0, 9'd0}));
        add_row(ask_row(32'sh8000_0000, 32'sh7fff_ffff, 1'b1,
                        cell_t'{DEEPEST, WD_MAX, 9'd0, 9'd0}));
        add_row(load_row(CMD_Z_WR, 0, 0, 0));
        add_row(ask_row(1, -1, 1'b1, cell_t'{SHALLOW_POS, 15'd0, 9'd0, 9'd0}));
        add_row(load_row(CMD_Z_WR, 0, 0, -19));
        add_row(ask_row(-1, 1, 1'b1,
                        cell_t'{SHALLOW_NEG, WD_W'(SHALLOW_LIMIT), 9'd0, 9'd0}));
        add_row(load_row(CMD_Z_WR, 0, 0, 32767));
        add_row(ask_row(32'sh7fff_ffff, 32'sh8000_0000, 1'b1,
                        cell_t'{16'sh7fff, 15'd0, 9'd0, 9'd0}));
        // three columns: walk right, stop on a midpoint, outer edge, cursor clamp
        add_row(reg_row(CFG_COLS_USED, 3));
        add_row(load_row(CMD_X_WR, 0, 0, 0));
        add_row(load_row(CMD_X_WR, 1, 0, 10));
        add_row(load_row(CMD_X_WR, 2, 0, 20));
        add_row(load_row(CMD_Z_WR, 1, 0, 50));
        add_row(load_row(CMD_Z_WR, 2, 0, -500));
        add_row(ask_row(15, 0, 1'b0, '0));
        add_row(ask_row(5, 0, 1'b0, '0));
        add_row(ask_row(32'sh7fff_ffff, 0, 1'b1,
                        cell_t'{-16'sd500, 15'd500, 9'd2, 9'd0}));
        add_row(reg_row(CFG_COLS_USED, 2));
        add_row(ask_row(0, 0, 1'b0, '0));

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                settle();
                set_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                push_word(plan[i].w, plan[i].known, plan[i].want);
            end
        end

        // random phases: pick a grid size, load it (or shrink the last one), then query
        loose   = 0;
        phase   = 0;
        fill_nc = 3;
        fill_nr = 1;
        while (loose < RANDOM_WORDS || phase < 4) begin
            bulky  = 1'b0;
            shrink = 1'b0;
            if (phase == 1) begin
                nc    = MAX_COLS;
                nr    = 1;
                bulky = 1'b1;
            end else if (phase == 3) begin
                nc    = 1;
                nr    = MAX_ROWS;
                bulky = 1'b1;
            end else if (phase != 0 && $urandom_range(0, 3) == 0) begin
                // no reload, so a far cursor gets clamped
                shrink = 1'b1;
                nc     = $urandom_range(1, fill_nc);
                nr     = $urandom_range(1, fill_nr);
            end else begin
                case ($urandom_range(0, 5))
                    0: begin
                        nc = $urandom_range(1, 64);
                        nr = $urandom_range(1, 2);
                    end
                    1: begin
                        nc = $urandom_range(1, 2);
                        nr = $urandom_range(1, 64);
                    end
                    default: begin
                        nc = $urandom_range(1, 6);
                        nr = $urandom_range(1, 6);
                    end
                endcase
            end
            calm = ($urandom_range(0, 4) == 0);

            settle();
            set_reg(CFG_COLS_USED, reg_code(nc, MAX_COLS));
            set_reg(CFG_ROWS_USED, reg_code(nr, MAX_ROWS));

            if (!shrink) begin
                fill_axis(CMD_X_WR, nc);
                fill_axis(CMD_Y_WR, nr);
                for (int r = 0; r < nr; r++) begin
                    for (int c = 0; c < nc; c++) begin
                        w       = blank_word();
                        w.cmd   = CMD_Z_WR;
                        w.col   = COL_W'(c);
                        w.row   = ROW_W'(r);
                        w.depth = pick_depth();
                        push_word(w, 1'b0, '0);
                    end
                end
                fill_nc = nc;
                fill_nr = nr;
                loose += nc + nr + nc * nr;
            end

            // mostly queries, a few stray loads that reset the cursor
            nq = bulky ? 60 : $urandom_range(8, 40);
            for (int i = 0; i < nq; i++) begin
                w = blank_word();
                if ($urandom_range(0, 9) != 0) begin
                    w.cmd     = CMD_QUERY;
                    w.query_x = aim(xs_mirror, nc);
                    w.query_y = aim(ys_mirror, nr);
                end else begin
                    w.cmd   = cmd_t'($urandom_range(0, 2));
                    w.depth = pick_depth();
                end
                push_word(w, 1'b0, '0);
            end
            loose += nq;
            phase++;
        end

        settle();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
